### sv/lpcf_pkg.sv
// Shared types and constants of the LED pulse crossfade frame block.
// Used by the channel interfaces and by every module of the block.
`default_nettype none
package lpcf_pkg;

  localparam int NUM_LEDS = 26;
  localparam int CNT_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [15:0] CHAN_ONE = 16'hFF00;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [7:0] OFF_BYTE = 8'hE0;

  localparam logic [23:0] RST_PERIOD = 24'd1000000;
  localparam logic [23:0] RST_FADE = 24'd125000;
  localparam logic [23:0] RST_SOLID = 24'd250000;
  localparam logic [23:0] RST_TRANS = 24'd500000;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_FRAME = 2'd2
  } kind_e;

  typedef enum logic [7:0] {
    REG_PERIOD = 8'd0,
    REG_FADE   = 8'd1,
    REG_SOLID  = 8'd2,
    REG_TRANS  = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] lit_first;
    logic [7:0] lit_last;
  } in_item_t;

  typedef struct packed {
    logic [4:0] led_index;
    logic [7:0] brightness_byte;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  index;
    logic [23:0] value;
  } cfg_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [23:0] color;
    logic [7:0]  lo;
    logic [7:0]  hi;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

### sv/lpcf_if.sv
// Valid/ready channel interfaces for input items, LED words and register writes.
// Depends on lpcf_pkg for the payload types.
`default_nettype none
interface lpcf_in_if;
  logic valid;
  logic ready;
  lpcf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpcf_out_if;
  logic valid;
  logic ready;
  lpcf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpcf_cfg_if;
  logic valid;
  logic ready;
  lpcf_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/led_pulse_crossfade_frame.sv
// Top level of the LED pulse crossfade frame block: front end, queue, back end
// and shared divider. Depends on lpcf_pkg, lpcf_if, lpcf_front, lpcf_div, lpcf_back.
//
//   channel  direction  payload
//   in_i     sink       kind, colour bytes, first and last LED
//   out_o    source     one APA102-style LED word per transaction
//   cfg_i    sink       register index and 24-bit value
//
// Start and tick transactions are handled by the idle back end once at the queue head.
// A frame takes up to six passes of the shared divider plus the sequencer states,
// then one LED word per cycle while the output is taken.
// Reset is asynchronous and active low; no clearing pass is needed.
// The four-entry queue lets input be taken while the back end waits on a stalled output.
`default_nettype none
module led_pulse_crossfade_frame (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lpcf_in_if.sink    in_i,
  lpcf_out_if.source out_o,
  lpcf_cfg_if.sink   cfg_i
);

  lpcf_pkg::q_head_t  head;
  logic               pop;
  lpcf_pkg::div_req_t div_req;
  lpcf_pkg::div_rsp_t div_rsp;

  lpcf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .head_o (head),
    .pop_i  (pop)
  );

  lpcf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lpcf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .head_i    (head),
    .pop_o     (pop),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp),
    .out_o     (out_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.last_of_frame)
      |-> (out_o.data.led_index == 5'(lpcf_pkg::NUM_LEDS - 1)))
    else $error("last word of frame has wrong index");

  a_next_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.data.last_of_frame)
      |=> (out_o.valid && (out_o.data.led_index == 5'($past(out_o.data.led_index) + 5'd1))))
    else $error("LED words of a frame not consecutive");

endmodule
`default_nettype wire

### sv/lpcf_front.sv
// Front end: accepts input transactions, drops unknown kinds, queues the rest.
// Depends on lpcf_pkg and lpcf_if.
`default_nettype none
module lpcf_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  lpcf_in_if.sink          in_i,
  output lpcf_pkg::q_head_t head_o,
  input  wire logic        pop_i
);

  localparam int DEPTH = lpcf_pkg::QUEUE_DEPTH;
  localparam int AW = lpcf_pkg::QUEUE_AW;
  localparam int QCW = AW + 1;

  lpcf_pkg::q_item_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic       known;
  logic       push;
  lpcf_pkg::q_item_t new_item;

  always_comb begin
    unique case (in_i.data.kind)
      lpcf_pkg::KIND_START, lpcf_pkg::KIND_TICK, lpcf_pkg::KIND_FRAME: known = 1'b1;
      default: known = 1'b0;
    endcase
    new_item.kind  = lpcf_pkg::kind_e'(in_i.data.kind);
    new_item.color = {in_i.data.red_in, in_i.data.green_in, in_i.data.blue_in};
    new_item.lo    = in_i.data.lit_first;
    new_item.hi    = in_i.data.lit_last;
  end

  assign in_i.ready = (cnt_q != QCW'(DEPTH));
  assign push = in_i.valid && in_i.ready && known;

  always_comb begin
    wr_d  = push ? wr_q + AW'(1) : wr_q;
    rd_d  = pop_i ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + QCW'(push) - QCW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_item;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

endmodule
`default_nettype wire

### sv/lpcf_div.sv
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on lpcf_pkg for the request and response types.
`default_nettype none
module lpcf_div (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire lpcf_pkg::div_req_t req_i,
  output lpcf_pkg::div_rsp_t rsp_o
);

  localparam int NW = lpcf_pkg::DIV_NW;
  localparam int DW = lpcf_pkg::DIV_DW;
  localparam int CW = lpcf_pkg::DIV_CW;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] acc_q, acc_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_sh;
  logic          fits;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q, acc_q[NW-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    if (busy_q) begin
      rem_d = fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      acc_d = {acc_q[NW-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      acc_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = acc_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

### sv/lpcf_back.sv
// Back end: holds the registers and pulse state, runs the frame sequencer
// and drives the LED word output register. Depends on lpcf_pkg and lpcf_if.
`default_nettype none
module lpcf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lpcf_cfg_if.sink           cfg_i,
  input  wire lpcf_pkg::q_head_t head_i,
  output logic               pop_o,
  output lpcf_pkg::div_req_t div_req_o,
  input  wire lpcf_pkg::div_rsp_t div_rsp_i,
  lpcf_out_if.source         out_o
);

  localparam int CW = lpcf_pkg::CNT_W;
  localparam logic [16:0] D17 = {1'b0, lpcf_pkg::CHAN_ONE};
  localparam logic [33:0] D_Q16 = 34'(lpcf_pkg::CHAN_ONE) << 16;
  localparam logic [33:0] TWO_D_Q16 = 34'(lpcf_pkg::CHAN_ONE) << 17;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_MOD    = 12'b0000_0000_0010,
    ST_FDIV   = 12'b0000_0000_0100,
    ST_TRANS  = 12'b0000_0000_1000,
    ST_TDIV   = 12'b0000_0001_0000,
    ST_MIX    = 12'b0000_0010_0000,
    ST_MAXMIN = 12'b0000_0100_0000,
    ST_LS     = 12'b0000_1000_0000,
    ST_LS2    = 12'b0001_0000_0000,
    ST_LS3    = 12'b0010_0000_0000,
    ST_LSW    = 12'b0100_0000_0000,
    ST_EMIT   = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic             fin;
    logic [16:0]      f;
    logic [16:0]      t;
    logic [2:0][15:0] ch;
    logic [15:0]      mx;
    logic [15:0]      mn;
    logic [7:0]       a;
    logic [7:0]       bri;
    logic [1:0]       k;
    logic [33:0]      lsf;
    logic [49:0]      big;
    logic             br_a;
    logic [2:0][7:0]  res;
  } dp_t;

  state_e      st_q, st_d;
  dp_t         dp_q, dp_d;
  logic [23:0] period_q, period_d, fade_q, fade_d, solid_q, solid_d, trans_q, trans_d;
  logic [23:0] cur_q, cur_d, pend_q, pend_d;
  logic        cur_vld_q, cur_vld_d, pend_vld_q, pend_vld_d;
  logic [23:0] phase_q, phase_d, elapsed_q, elapsed_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;
  logic        lit_q, lit_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        out_vld_q, out_vld_d;
  lpcf_pkg::out_item_t out_q, out_d;

  logic [23:0] period_eff, p, p1, p2;
  logic [24:0] phase_inc;
  logic [2:0][15:0] mix_ch;
  logic [24:0] mix_sum [3];
  logic [1:0]  ci;
  logic [15:0] x;
  logic [16:0] ls, g, dxl;
  logic [32:0] xf;
  logic [13:0] v;
  logic [39:0] qv;
  logic [7:0]  r8, idx8;
  logic        on;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_sum[k] = 25'(cur_q[8*(2-k) +: 8]) * (25'(lpcf_pkg::ONE_Q16) - 25'(dp_q.t))
                 + 25'(pend_q[8*(2-k) +: 8]) * 25'(dp_q.t);
      mix_ch[k] = 16'(mix_sum[k] >> 8);
    end
  end

  assign cfg_i.ready = 1'b1;
  assign period_eff = (period_q == 24'd0) ? 24'd1 : period_q;
  assign phase_inc  = {1'b0, phase_q} + 25'd1;
  assign p   = div_rsp_i.rem;
  assign p1  = p - fade_q;
  assign p2  = p1 - solid_q;
  assign ci  = 2'd2 - dp_q.k;
  assign x   = dp_q.ch[ci];
  assign ls  = 17'(dp_q.mx) + 17'(dp_q.mn);
  assign g   = (D17 << 1) - ls;
  assign dxl = D17 + 17'(x) - ls;
  assign xf  = 33'(x) * 33'(dp_q.f);
  assign v   = 14'(dp_q.a) * 14'd31;
  assign qv  = div_rsp_i.quot;
  assign idx8 = 8'(idx_q);
  assign on  = lit_q && (idx8 >= lo_q) && (idx8 <= hi_q);

  always_comb begin
    if (dp_q.br_a) begin
      r8 = (|qv[39:8]) ? 8'hFF : qv[7:0];
    end else begin
      r8 = (|qv[39:8]) ? 8'h00 : 8'hFF - qv[7:0];
    end
  end

  always_comb begin
    st_d = st_q;
    dp_d = dp_q;
    period_d = period_q;
    fade_d = fade_q;
    solid_d = solid_q;
    trans_d = trans_q;
    cur_d = cur_q;
    pend_d = pend_q;
    cur_vld_d = cur_vld_q;
    pend_vld_d = pend_vld_q;
    phase_d = phase_q;
    elapsed_d = elapsed_q;
    lo_d = lo_q;
    hi_d = hi_q;
    lit_d = lit_q;
    idx_d = idx_q;
    out_vld_d = out_vld_q;
    out_d = out_q;
    pop_o = 1'b0;
    div_req_o = '0;

    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        lpcf_pkg::REG_PERIOD: period_d = cfg_i.data.value;
        lpcf_pkg::REG_FADE:   fade_d = cfg_i.data.value;
        lpcf_pkg::REG_SOLID:  solid_d = cfg_i.data.value;
        lpcf_pkg::REG_TRANS:  trans_d = cfg_i.data.value;
        default: ;
      endcase
    end

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          unique case (head_i.item.kind)
            lpcf_pkg::KIND_START: begin
              lo_d = head_i.item.lo;
              hi_d = head_i.item.hi;
              if (!cur_vld_q) begin
                cur_d = head_i.item.color;
                cur_vld_d = 1'b1;
                phase_d = 24'd0;
              end else begin
                pend_d = head_i.item.color;
                pend_vld_d = 1'b1;
                elapsed_d = 24'd0;
              end
            end
            lpcf_pkg::KIND_TICK: begin
              phase_d = (phase_inc >= {1'b0, period_eff}) ? 24'd0 : phase_inc[23:0];
              if (elapsed_q != 24'hFFFFFF) begin
                elapsed_d = elapsed_q + 24'd1;
              end
            end
            lpcf_pkg::KIND_FRAME: begin
              if (!cur_vld_q) begin
                lit_d = 1'b0;
                idx_d = '0;
                st_d = ST_EMIT;
              end else begin
                div_req_o.start = 1'b1;
                div_req_o.num = 40'(phase_q);
                div_req_o.den = period_eff;
                st_d = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (!div_rsp_i.busy) begin
          if (p < fade_q) begin
            div_req_o.start = 1'b1;
            div_req_o.num = {p, 16'd0};
            div_req_o.den = fade_q;
            dp_d.fin = 1'b1;
            st_d = ST_FDIV;
          end else if (p1 < solid_q) begin
            dp_d.f = lpcf_pkg::ONE_Q16;
            st_d = ST_TRANS;
          end else if (p2 < fade_q) begin
            div_req_o.start = 1'b1;
            div_req_o.num = {p2, 16'd0};
            div_req_o.den = fade_q;
            dp_d.fin = 1'b0;
            st_d = ST_FDIV;
          end else begin
            if (pend_vld_q) begin
              cur_d = pend_q;
              pend_vld_d = 1'b0;
            end
            lit_d = 1'b0;
            idx_d = '0;
            st_d = ST_EMIT;
          end
        end
      end
      ST_FDIV: begin
        if (!div_rsp_i.busy) begin
          dp_d.f = dp_q.fin ? qv[16:0] : lpcf_pkg::ONE_Q16 - qv[16:0];
          st_d = ST_TRANS;
        end
      end
      ST_TRANS: begin
        if (!pend_vld_q) begin
          dp_d.t = 17'd0;
          st_d = ST_MIX;
        end else if (trans_q == 24'd0 || elapsed_q >= trans_q) begin
          dp_d.t = lpcf_pkg::ONE_Q16;
          st_d = ST_MIX;
        end else begin
          div_req_o.start = 1'b1;
          div_req_o.num = {elapsed_q, 16'd0};
          div_req_o.den = trans_q;
          st_d = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (!div_rsp_i.busy) begin
          dp_d.t = qv[16:0];
          st_d = ST_MIX;
        end
      end
      ST_MIX: begin
        dp_d.ch = mix_ch;
        dp_d.a = 8'((25'(dp_q.f) * 25'd255) >> 16);
        st_d = ST_MAXMIN;
      end
      ST_MAXMIN: begin
        dp_d.mx = dp_q.ch[0];
        dp_d.mn = dp_q.ch[0];
        for (int k = 1; k < 3; k++) begin
          if (dp_q.ch[k] > dp_d.mx) dp_d.mx = dp_q.ch[k];
          if (dp_q.ch[k] < dp_d.mn) dp_d.mn = dp_q.ch[k];
        end
        dp_d.bri = lpcf_pkg::OFF_BYTE | 8'((v + (v >> 8) + 14'd1) >> 8);
        dp_d.k = 2'd0;
        st_d = ST_LS;
      end
      ST_LS: begin
        if (dp_q.mx == dp_q.mn || ls <= D17) begin
          dp_d.res[dp_q.k] = 8'(xf >> 24);
          if (dp_q.k == 2'd2) begin
            lit_d = 1'b1;
            idx_d = '0;
            st_d = ST_EMIT;
          end else begin
            dp_d.k = dp_q.k + 2'd1;
          end
        end else begin
          dp_d.lsf = 34'(ls) * 34'(dp_q.f);
          st_d = ST_LS2;
        end
      end
      ST_LS2: begin
        if (dp_q.lsf <= D_Q16) begin
          dp_d.br_a = 1'b1;
          dp_d.big = 50'(dp_q.lsf) * 50'(dxl[15:0]);
        end else begin
          dp_d.br_a = 1'b0;
          dp_d.big = 50'(TWO_D_Q16 - dp_q.lsf) * 50'(lpcf_pkg::CHAN_ONE - x);
        end
        st_d = ST_LS3;
      end
      ST_LS3: begin
        div_req_o.start = 1'b1;
        div_req_o.den = 24'(g);
        if (dp_q.br_a) begin
          div_req_o.num = 40'(dp_q.big[49:24]);
        end else begin
          div_req_o.num = 40'(dp_q.big[49:24]) + 40'(|dp_q.big[23:0]) + 40'(g) - 40'd1;
        end
        st_d = ST_LSW;
      end
      ST_LSW: begin
        if (!div_rsp_i.busy) begin
          dp_d.res[dp_q.k] = r8;
          if (dp_q.k == 2'd2) begin
            lit_d = 1'b1;
            idx_d = '0;
            st_d = ST_EMIT;
          end else begin
            dp_d.k = dp_q.k + 2'd1;
            st_d = ST_LS;
          end
        end
      end
      ST_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_d.led_index = idx8[4:0];
          out_d.brightness_byte = on ? dp_q.bri : lpcf_pkg::OFF_BYTE;
          out_d.blue_out = on ? dp_q.res[0] : 8'd0;
          out_d.green_out = on ? dp_q.res[1] : 8'd0;
          out_d.red_out = on ? dp_q.res[2] : 8'd0;
          out_d.last_of_frame = (idx_q == CW'(lpcf_pkg::NUM_LEDS - 1));
          if (idx_q == CW'(lpcf_pkg::NUM_LEDS - 1)) begin
            st_d = ST_IDLE;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      period_q <= lpcf_pkg::RST_PERIOD;
      fade_q <= lpcf_pkg::RST_FADE;
      solid_q <= lpcf_pkg::RST_SOLID;
      trans_q <= lpcf_pkg::RST_TRANS;
      cur_q <= 24'd0;
      pend_q <= 24'd0;
      cur_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      phase_q <= 24'd0;
      elapsed_q <= 24'd0;
      lo_q <= 8'd0;
      hi_q <= 8'd0;
      lit_q <= 1'b0;
      idx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      period_q <= period_d;
      fade_q <= fade_d;
      solid_q <= solid_d;
      trans_q <= trans_d;
      cur_q <= cur_d;
      pend_q <= pend_d;
      cur_vld_q <= cur_vld_d;
      pend_vld_q <= pend_vld_d;
      phase_q <= phase_d;
      elapsed_q <= elapsed_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
      lit_q <= lit_d;
      idx_q <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dp_q <= dp_d;
    out_q <= out_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire
